@@ rtl/ssou_pkg.sv @@
// Package for the segmented string op unit: op and status codes, and the
// packed input and result types. No dependencies.
`default_nettype none
package ssou_pkg;
  localparam logic [2:0] OP_COPY  = 3'd0;
  localparam logic [2:0] OP_FILL  = 3'd1;
  localparam logic [2:0] OP_FIND  = 3'd2;
  localparam logic [2:0] OP_CMP   = 3'd3;
  localparam logic [2:0] OP_WRITE = 3'd4;
  localparam logic [2:0] OP_READ  = 3'd5;

  localparam logic [1:0] ST_OK      = 2'd0;
  localparam logic [1:0] ST_MISSING = 2'd1;
  localparam logic [1:0] ST_FAULT   = 2'd2;
  localparam logic [1:0] ST_IGNORED = 2'd3;

  typedef struct packed {
    logic [2:0]  op;
    logic [3:0]  src_segment;
    logic [11:0] src_offset;
    logic [12:0] count;
    logic [3:0]  dst_segment;
    logic [11:0] dst_offset;
    logic [7:0]  byte_value;
    logic [11:0] src_seg_len;
    logic [11:0] dst_seg_len;
  } in_item_t;

  typedef struct packed {
    logic [12:0] new_src_offset;
    logic [12:0] new_count;
    logic [12:0] new_dst_offset;
    logic [1:0]  status;
    logic [7:0]  read_data;
  } out_item_t;
endpackage
`default_nettype wire

@@ rtl/ssou_ram.sv @@
// Generic single-port RAM with registered read data.
// No dependencies.
`default_nettype none
module ssou_ram #(
  parameter int Width = 8,
  parameter int Depth = 256
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(Depth)-1:0] addr,
  input  wire logic [Width-1:0]         wdata,
  output logic      [Width-1:0]         rdata
);
  logic [Width-1:0] mem [Depth];
  always_ff @(posedge clk) begin
    if (we) begin
      mem[addr] <= wdata;
    end
    rdata <= mem[addr];
  end
endmodule
`default_nettype wire

@@ rtl/segmented_string_op_unit.sv @@
// Top level of the segmented string op unit: checks, sequencer and memory.
// Depends on ssou_pkg and ssou_ram.
`default_nettype none
// Usage: drive in_data and raise start while busy is low; that edge is the
// transfer of one instruction. busy then stays high until the result appears
// on out_data with out_valid high for exactly one cycle; the receiver cannot
// stall and must take it then. One instruction is worked on at a time.
// A rejected or zero-length instruction goes from S_CHECK straight to S_DONE.
// Fill walks one byte per cycle in S_RD_A. Find and compare read one byte at
// a time through the single memory port, whose read data is registered: find
// steps through S_RD_A and S_EVAL per byte, compare through S_RD_A, S_RD_B and
// S_EVAL (two reads). Copy runs every byte through a read in S_RD_A and a write
// in S_RD_B; it walks backward when the destination lies above the source, so
// overlapping ranges copy as if the source were read in full first. A write
// goes from S_CHECK to S_DONE and a read through S_RD_A and S_EVAL. Every op
// shares the single memory port. Reset clears only the control state; memory
// contents are undefined until written and need no clearing pass.
module segmented_string_op_unit #(
  parameter int SEGMENT_COUNT = 16,
  parameter int SEGMENT_BYTES = 4096
) (
  input  wire logic               clk,
  input  wire logic               rst_n,
  input  wire logic               start,
  output logic                    busy,
  input  wire ssou_pkg::in_item_t in_data,
  output logic                    out_valid,
  output ssou_pkg::out_item_t     out_data
);
  import ssou_pkg::*;

  localparam int OffW  = $clog2(SEGMENT_BYTES);
  localparam int Depth = SEGMENT_COUNT * SEGMENT_BYTES;
  localparam int AddrW = $clog2(Depth);

  localparam logic [2:0] S_IDLE  = 3'd0;
  localparam logic [2:0] S_CHECK = 3'd1;
  localparam logic [2:0] S_RD_A  = 3'd2;  // address src byte
  localparam logic [2:0] S_RD_B  = 3'd3;  // src data back, address dst byte
  localparam logic [2:0] S_EVAL  = 3'd4;  // last read data back
  localparam logic [2:0] S_DONE  = 3'd5;

  logic [2:0]  state_r, state_nxt;
  in_item_t    it_r;
  logic [12:0] idx_r, idx_nxt;      // bytes done
  logic        back_r, back_nxt;    // copy walks from the end
  logic [7:0]  a_r, a_nxt;          // first byte of compare, or copy data
  out_item_t   res_r, res_nxt;
  logic        ov_r, ov_nxt;

  logic                 we;
  logic [AddrW-1:0]     addr;
  logic [7:0]           wdata, rdata;

  ssou_ram #(.Width(8), .Depth(Depth)) u_mem (
    .clk(clk), .we(we), .addr(addr), .wdata(wdata), .rdata(rdata)
  );

  // Range test len < off + n - 1 on 14-bit sums; n = 0 at off = 0 passes.
  function automatic logic oor(input logic [11:0] len, input logic [11:0] off,
                               input logic [12:0] n);
    logic [13:0] s;
    s = {2'b0, off} + {1'b0, n};
    return (s != 14'd0) && ({2'b0, len} < s - 14'd1);
  endfunction

  function automatic logic [AddrW-1:0] mk(input logic [3:0] seg,
                                          input logic [12:0] off);
    logic [AddrW+3:0] a;
    a = (AddrW + 4)'(32'(seg) % SEGMENT_COUNT) * (AddrW + 4)'(SEGMENT_BYTES)
      + (AddrW + 4)'(off[OffW-1:0]);
    return a[AddrW-1:0];
  endfunction

  // Byte positions of the current step.
  logic [12:0] pos, spos, dpos;
  always_comb begin
    pos  = back_r ? (it_r.count - 13'd1 - idx_r) : idx_r;
    spos = {1'b0, it_r.src_offset} + pos;
    dpos = {1'b0, it_r.dst_offset} + pos;
  end

  always_comb begin
    state_nxt = state_r;
    idx_nxt   = idx_r;
    back_nxt  = back_r;
    a_nxt     = a_r;
    res_nxt   = res_r;
    ov_nxt    = 1'b0;
    we        = 1'b0;
    addr      = mk(it_r.src_segment, spos);
    wdata     = it_r.byte_value;
    case (state_r)
      S_IDLE: begin
        if (start) begin
          state_nxt = S_CHECK;
          idx_nxt   = 13'd0;
          back_nxt  = (in_data.op == OP_COPY) &&
                      ({in_data.dst_segment, in_data.dst_offset} >
                       {in_data.src_segment, in_data.src_offset});
        end
      end
      S_CHECK: begin
        res_nxt.new_src_offset = {1'b0, it_r.src_offset};
        res_nxt.new_count      = it_r.count;
        res_nxt.new_dst_offset = {1'b0, it_r.dst_offset};
        res_nxt.status         = ST_OK;
        res_nxt.read_data      = 8'd0;
        state_nxt              = S_DONE;
        case (it_r.op)
          OP_COPY, OP_CMP: begin
            if (it_r.src_seg_len == 12'd0 || it_r.dst_seg_len == 12'd0) begin
              res_nxt.status = ST_MISSING;
            end else if (oor(it_r.src_seg_len, it_r.src_offset, it_r.count) ||
                         oor(it_r.dst_seg_len, it_r.dst_offset, it_r.count)) begin
              res_nxt.status = ST_FAULT;
            end else if (it_r.count != 13'd0) begin
              state_nxt = S_RD_A;
            end
          end
          OP_FILL, OP_FIND: begin
            if (it_r.src_seg_len == 12'd0) begin
              res_nxt.status = ST_MISSING;
            end else if (oor(it_r.src_seg_len, it_r.src_offset, it_r.count)) begin
              res_nxt.status = ST_IGNORED;
            end else if (it_r.count != 13'd0) begin
              state_nxt = S_RD_A;
            end
          end
          OP_WRITE: begin
            if (it_r.dst_seg_len == 12'd0) begin
              res_nxt.status = ST_MISSING;
            end else if (oor(it_r.dst_seg_len, it_r.dst_offset, 13'd1)) begin
              res_nxt.status = ST_FAULT;
            end else begin
              we    = 1'b1;
              addr  = mk(it_r.dst_segment, {1'b0, it_r.dst_offset});
            end
          end
          OP_READ: begin
            if (it_r.src_seg_len == 12'd0) begin
              res_nxt.status = ST_MISSING;
            end else if (oor(it_r.src_seg_len, it_r.src_offset, 13'd1)) begin
              res_nxt.status = ST_FAULT;
            end else begin
              state_nxt = S_RD_A;
            end
          end
          default: ;
        endcase
      end
      S_RD_A: begin
        if (it_r.op == OP_FILL) begin
          we      = 1'b1;
          idx_nxt = idx_r + 13'd1;
          if (idx_r + 13'd1 == it_r.count) begin
            res_nxt.new_src_offset = spos + 13'd1;
            res_nxt.new_count      = 13'd0;
            state_nxt              = S_DONE;
          end
        end else if (it_r.op == OP_COPY || it_r.op == OP_CMP) begin
          state_nxt = S_RD_B;
        end else begin
          state_nxt = S_EVAL;
        end
      end
      S_RD_B: begin
        a_nxt = rdata;
        if (it_r.op == OP_COPY) begin
          // Source data is back: write it to the destination.
          we      = 1'b1;
          addr    = mk(it_r.dst_segment, dpos);
          wdata   = rdata;
          idx_nxt = idx_r + 13'd1;
          if (idx_r + 13'd1 == it_r.count) begin
            res_nxt.new_src_offset = {1'b0, it_r.src_offset} + it_r.count;
            res_nxt.new_dst_offset = {1'b0, it_r.dst_offset} + it_r.count;
            res_nxt.new_count      = 13'd0;
            state_nxt              = S_DONE;
          end else begin
            state_nxt = S_RD_A;
          end
        end else begin
          addr      = mk(it_r.dst_segment, dpos);
          state_nxt = S_EVAL;
        end
      end
      S_EVAL: begin
        if (it_r.op == OP_READ) begin
          res_nxt.read_data = rdata;
          state_nxt         = S_DONE;
        end else begin
          // Find compares against the search byte, compare against the src byte.
          if ((it_r.op == OP_FIND) ? (rdata == it_r.byte_value) : (rdata != a_r)) begin
            res_nxt.new_src_offset = spos;
            res_nxt.new_dst_offset = (it_r.op == OP_CMP) ? dpos
                                                         : {1'b0, it_r.dst_offset};
            res_nxt.new_count      = it_r.count - idx_r;
            state_nxt              = S_DONE;
          end else if (idx_r + 13'd1 == it_r.count) begin
            res_nxt.new_src_offset = spos + 13'd1;
            res_nxt.new_dst_offset = (it_r.op == OP_CMP) ? dpos + 13'd1
                                                         : {1'b0, it_r.dst_offset};
            res_nxt.new_count      = 13'd0;
            state_nxt              = S_DONE;
          end else begin
            idx_nxt   = idx_r + 13'd1;
            state_nxt = S_RD_A;
          end
        end
      end
      S_DONE: begin
        ov_nxt    = 1'b1;
        state_nxt = S_IDLE;
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      ov_r    <= 1'b0;
    end else begin
      state_r <= state_nxt;
      ov_r    <= ov_nxt;
    end
    if (state_r == S_IDLE && start) begin
      it_r <= in_data;
    end
    idx_r  <= idx_nxt;
    back_r <= back_nxt;
    a_r    <= a_nxt;
    res_r  <= res_nxt;
  end

  assign busy      = (state_r != S_IDLE);
  assign out_valid = ov_r;
  assign out_data  = res_r;
endmodule
`default_nettype wire

@@ tb/sv/tb_segmented_string_op_unit.sv @@
// Self-checking testbench for segmented_string_op_unit: it drives string
// instructions from a queue, predicts each result and checks the result port.
// Depends on ssou_pkg and the segmented_string_op_unit RTL.
`timescale 1ns / 100ps
`default_nettype none
module tb_segmented_string_op_unit;
  import ssou_pkg::*;

  localparam int SEG_COUNT = 16;
  localparam int SEG_BYTES = 4096;
  localparam int MEM_BYTES = SEG_COUNT * SEG_BYTES;

  logic      clk;
  logic      rst_n;
  logic      start;
  logic      busy;
  in_item_t  in_data;
  logic      out_valid;
  out_item_t out_data;

  segmented_string_op_unit #(
    .SEGMENT_COUNT(SEG_COUNT),
    .SEGMENT_BYTES(SEG_BYTES)
  ) uut (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (start),
    .busy     (busy),
    .in_data  (in_data),
    .out_valid(out_valid),
    .out_data (out_data)
  );

  // Clock with a 4 ns period.
  always begin
    clk = 1'b1;
    #2;
    clk = 1'b0;
    #2;
  end

  // Shadow copy of the byte memory, kept in step with the instructions as
  // they are queued. Every instruction is accepted in queue order, so the
  // shadow always matches the memory as seen by the next instruction.
  logic [7:0] shadow_mem [MEM_BYTES];

  in_item_t  instr_queue[$];
  out_item_t result_queue[$];

  int unsigned instr_sent;
  int unsigned results_seen;
  int unsigned error_count;
  int unsigned op_tally [8];
  int unsigned status_tally [4];
  bit          stimulus_done;

  function automatic int unsigned mem_addr(logic [3:0] seg, int unsigned off);
    return int'(seg) * SEG_BYTES + (off % SEG_BYTES);
  endfunction

  // A range at offset off of n bytes is out of range when len < off + n - 1,
  // taken as signed so that an empty range at offset 0 is still in range.
  function automatic bit range_fault(int len, int off, int n);
    return len < off + n - 1;
  endfunction

  // Works out the result of one instruction and applies its memory effects.
  function automatic out_item_t run_string_op(in_item_t it);
    out_item_t   res;
    int unsigned cnt;
    int unsigned i;
    logic [7:0]  copy_buf[];
    cnt = it.count;
    res.new_src_offset = 13'(it.src_offset);
    res.new_count      = it.count;
    res.new_dst_offset = 13'(it.dst_offset);
    res.status         = ST_OK;
    res.read_data      = 8'h00;
    case (it.op)
      OP_COPY, OP_CMP: begin
        if (it.src_seg_len == 0 || it.dst_seg_len == 0) begin
          res.status = ST_MISSING;
        end else if (range_fault(it.src_seg_len, it.src_offset, cnt) ||
                     range_fault(it.dst_seg_len, it.dst_offset, cnt)) begin
          res.status = ST_FAULT;
        end else if (it.op == OP_COPY) begin
          // Read the whole source first so that overlapping ranges behave.
          copy_buf = new[cnt];
          for (i = 0; i < cnt; i++)
            copy_buf[i] = shadow_mem[mem_addr(it.src_segment, it.src_offset + i)];
          for (i = 0; i < cnt; i++)
            shadow_mem[mem_addr(it.dst_segment, it.dst_offset + i)] = copy_buf[i];
          res.new_src_offset = 13'(it.src_offset + cnt);
          res.new_dst_offset = 13'(it.dst_offset + cnt);
          res.new_count      = '0;
        end else begin
          i = 0;
          while (i < cnt &&
                 shadow_mem[mem_addr(it.src_segment, it.src_offset + i)] ==
                 shadow_mem[mem_addr(it.dst_segment, it.dst_offset + i)])
            i++;
          res.new_src_offset = 13'(it.src_offset + i);
          res.new_dst_offset = 13'(it.dst_offset + i);
          res.new_count      = 13'(cnt - i);
        end
      end
      OP_FILL, OP_FIND: begin
        if (it.src_seg_len == 0) begin
          res.status = ST_MISSING;
        end else if (range_fault(it.src_seg_len, it.src_offset, cnt)) begin
          res.status = ST_IGNORED;
        end else if (it.op == OP_FILL) begin
          for (i = 0; i < cnt; i++)
            shadow_mem[mem_addr(it.src_segment, it.src_offset + i)] = it.byte_value;
          res.new_src_offset = 13'(it.src_offset + cnt);
          res.new_count      = '0;
        end else begin
          i = 0;
          while (i < cnt &&
                 shadow_mem[mem_addr(it.src_segment, it.src_offset + i)] != it.byte_value)
            i++;
          res.new_src_offset = 13'(it.src_offset + i);
          res.new_count      = 13'(cnt - i);
        end
      end
      OP_WRITE: begin
        if (it.dst_seg_len == 0) begin
          res.status = ST_MISSING;
        end else if (range_fault(it.dst_seg_len, it.dst_offset, 1)) begin
          res.status = ST_FAULT;
        end else begin
          shadow_mem[mem_addr(it.dst_segment, it.dst_offset)] = it.byte_value;
        end
      end
      OP_READ: begin
        if (it.src_seg_len == 0) begin
          res.status = ST_MISSING;
        end else if (range_fault(it.src_seg_len, it.src_offset, 1)) begin
          res.status = ST_FAULT;
        end else begin
          res.read_data = shadow_mem[mem_addr(it.src_segment, it.src_offset)];
        end
      end
      default: ;
    endcase
    return res;
  endfunction

  // Queues one instruction together with its predicted result.
  task automatic queue_instr(in_item_t it);
    instr_queue.push_back(it);
    result_queue.push_back(run_string_op(it));
    op_tally[it.op]++;
    status_tally[result_queue[$].status]++;
  endtask

  function automatic in_item_t make_instr(logic [2:0] op, int sseg, int soff, int cnt,
                                          int dseg, int doff, int bval, int slen,
                                          int dlen);
    in_item_t it;
    it.op          = op;
    it.src_segment = 4'(sseg);
    it.src_offset  = 12'(soff);
    it.count       = 13'(cnt);
    it.dst_segment = 4'(dseg);
    it.dst_offset  = 12'(doff);
    it.byte_value  = 8'(bval);
    it.src_seg_len = 12'(slen);
    it.dst_seg_len = 12'(dlen);
    return it;
  endfunction

  // Random instruction. Lengths are mostly present and offsets mostly inside
  // the segment, so that most instructions do real work; counts are mostly
  // short with an occasional long run. The whole memory is initialized before
  // any of these run, so no read ever hits an unwritten byte.
  task automatic queue_random_instr();
    in_item_t    it;
    int unsigned pick;
    int unsigned span;
    pick = $urandom_range(0, 99);
    if (pick < 20)      it.op = OP_COPY;
    else if (pick < 35) it.op = OP_FILL;
    else if (pick < 55) it.op = OP_FIND;
    else if (pick < 75) it.op = OP_CMP;
    else if (pick < 85) it.op = OP_WRITE;
    else if (pick < 96) it.op = OP_READ;
    else                it.op = 3'($urandom_range(6, 7));
    it.src_segment = 4'($urandom);
    it.dst_segment = 4'($urandom);
    it.byte_value  = 8'($urandom);
    it.src_seg_len = ($urandom_range(0, 19) == 0) ? 12'd0 : 12'($urandom_range(1, 4095));
    it.dst_seg_len = ($urandom_range(0, 19) == 0) ? 12'd0 : 12'($urandom_range(1, 4095));
    it.src_offset  = ($urandom_range(0, 9) == 0) ? 12'($urandom)
                                                 : 12'($urandom_range(0, it.src_seg_len));
    it.dst_offset  = ($urandom_range(0, 9) == 0) ? 12'($urandom)
                                                 : 12'($urandom_range(0, it.dst_seg_len));
    pick = $urandom_range(0, 99);
    if (pick < 3) begin
      it.count = 13'($urandom_range(0, 4096));
    end else if (pick < 10) begin
      it.count = 13'($urandom_range(0, 8191));
    end else begin
      it.count = 13'($urandom_range(0, 40));
    end
    // Compare of two identical ranges runs to the end without a mismatch.
    if (it.op == OP_CMP && $urandom_range(0, 2) == 0) begin
      it.dst_segment = it.src_segment;
      it.dst_offset  = it.src_offset;
      it.dst_seg_len = it.src_seg_len;
    end
    // Search for a byte that sits somewhere in the range, so finds hit.
    if (it.op == OP_FIND && it.count != 0 && $urandom_range(0, 1) == 0) begin
      span = $urandom_range(0, it.count - 1);
      it.byte_value = shadow_mem[mem_addr(it.src_segment, it.src_offset + span)];
    end
    queue_instr(it);
  endtask

  // Stimulus: initialize every segment, run the directed cases, then random.
  initial begin
    int n;
    for (n = 0; n < SEG_COUNT; n++)
      queue_instr(make_instr(OP_FILL, n, 0, 4096, 0, 0, $urandom, 4095, 0));
    // Overlapping copies in both directions, and the full-size copy.
    queue_instr(make_instr(OP_COPY, 1, 10, 30, 1, 20, 0, 4095, 4095));
    queue_instr(make_instr(OP_COPY, 2, 20, 30, 2, 10, 0, 4095, 4095));
    queue_instr(make_instr(OP_COPY, 3, 0, 4096, 4, 0, 0, 4095, 4095));
    // Full-size compare that matches, then a mismatch in the middle.
    queue_instr(make_instr(OP_CMP, 3, 0, 4096, 4, 0, 0, 4095, 4095));
    queue_instr(make_instr(OP_WRITE, 0, 0, 0, 4, 100, 8'hA5, 0, 4095));
    queue_instr(make_instr(OP_WRITE, 0, 0, 0, 3, 100, 8'h5A, 0, 4095));
    queue_instr(make_instr(OP_CMP, 3, 90, 20, 4, 90, 0, 4095, 4095));
    // Zero counts: compare and find at offset zero with the smallest segment.
    queue_instr(make_instr(OP_CMP, 5, 0, 0, 6, 0, 0, 1, 1));
    queue_instr(make_instr(OP_FIND, 5, 0, 0, 0, 0, 0, 1, 0));
    // Missing segments and out-of-range faults and silent no-ops.
    queue_instr(make_instr(OP_COPY, 5, 0, 4, 6, 0, 0, 0, 100));
    queue_instr(make_instr(OP_CMP, 5, 0, 4, 6, 0, 0, 100, 0));
    queue_instr(make_instr(OP_COPY, 5, 4095, 2, 6, 0, 0, 4095, 100));
    queue_instr(make_instr(OP_FILL, 15, 4095, 4096, 0, 0, 8'hFF, 4095, 0));
    queue_instr(make_instr(OP_FIND, 15, 50, 10, 0, 0, 8'h00, 0, 0));
    // Byte write and read at the last offset, in range and just out of it.
    queue_instr(make_instr(OP_WRITE, 0, 0, 0, 15, 4095, 8'hFF, 0, 4095));
    queue_instr(make_instr(OP_READ, 15, 4095, 0, 0, 0, 0, 4095, 0));
    queue_instr(make_instr(OP_READ, 15, 4095, 0, 0, 0, 0, 4094, 0));
    queue_instr(make_instr(OP_WRITE, 0, 0, 0, 15, 4095, 8'h00, 0, 4094));
    queue_instr(make_instr(3'd7, 15, 4095, 8191, 15, 4095, 8'hFF, 4095, 4095));
    for (n = 0; n < 480; n++)
      queue_random_instr();
    stimulus_done = 1'b1;
  end

  // Driver. The sender works in bursts of random length separated by random
  // gaps; a gap of zero gives stretches of back-to-back instructions. An
  // instruction is held on in_data until the edge that transfers it.
  int unsigned burst_left;
  int unsigned gap_left;

  always @(posedge clk) begin
    bit transfer;
    bit holding;
    transfer = start && !busy;
    holding  = start && !transfer;
    if (!rst_n) begin
      start      <= 1'b0;
      in_data    <= '0;
      burst_left <= 0;
      gap_left   <= 0;
    end else begin
      if (transfer)
        instr_sent <= instr_sent + 1;
      if (!holding) begin
        if (gap_left != 0) begin
          gap_left <= gap_left - 1;
          start    <= 1'b0;
        end else if (instr_queue.size() != 0) begin
          in_data <= instr_queue.pop_front();
          start   <= 1'b1;
          if (burst_left == 0) begin
            burst_left <= $urandom_range(1, 12);
            gap_left   <= ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 10);
          end else begin
            burst_left <= burst_left - 1;
          end
        end else begin
          start <= 1'b0;
        end
      end
    end
  end

  // Monitor. Each strobed result is checked against the oldest prediction.
  always @(posedge clk) begin
    out_item_t want;
    if (rst_n && out_valid) begin
      results_seen <= results_seen + 1;
      if (result_queue.size() == 0) begin
        $error("result arrived with no instruction outstanding: %p", out_data);
        error_count++;
      end else begin
        want = result_queue.pop_front();
        if (out_data.new_src_offset !== want.new_src_offset) begin
          $error("new_src_offset: expected %0d, got %0d",
                 want.new_src_offset, out_data.new_src_offset);
          error_count++;
        end
        if (out_data.new_count !== want.new_count) begin
          $error("new_count: expected %0d, got %0d", want.new_count, out_data.new_count);
          error_count++;
        end
        if (out_data.new_dst_offset !== want.new_dst_offset) begin
          $error("new_dst_offset: expected %0d, got %0d",
                 want.new_dst_offset, out_data.new_dst_offset);
          error_count++;
        end
        if (out_data.status !== want.status) begin
          $error("status: expected %0d, got %0d", want.status, out_data.status);
          error_count++;
        end
        if (out_data.read_data !== want.read_data) begin
          $error("read_data: expected 0x%02h, got 0x%02h",
                 want.read_data, out_data.read_data);
          error_count++;
        end
      end
    end
  end

  // Reset, then wait until every instruction has been transferred and every
  // result has come back, then keep running to catch stray results.
  initial begin
    rst_n         = 1'b0;
    start         = 1'b0;
    in_data       = '0;
    instr_sent    = 0;
    results_seen  = 0;
    error_count   = 0;
    repeat (4) @(posedge clk);
    rst_n <= 1'b1;
    wait (stimulus_done && instr_queue.size() == 0 && !start && result_queue.size() == 0);
    repeat (20) @(posedge clk);
    $display("Ran %0d instructions, %0d results: copy %0d fill %0d find %0d cmp %0d",
             instr_sent, results_seen, op_tally[OP_COPY], op_tally[OP_FILL],
             op_tally[OP_FIND], op_tally[OP_CMP]);
    $display("  write %0d read %0d unused %0d; status ok %0d missing %0d fault %0d ign %0d",
             op_tally[OP_WRITE], op_tally[OP_READ], op_tally[6] + op_tally[7],
             status_tally[ST_OK], status_tally[ST_MISSING], status_tally[ST_FAULT],
             status_tally[ST_IGNORED]);
    if (error_count == 0 && result_queue.size() == 0) begin
      $display("PASSED: all results match");
    end else begin
      $display("FAILED: results differ");
    end
    $finish;
  end

  // Watchdog well beyond the slowest correct run.
  initial begin
    #8ms;
    $display("Timeout with %0d results outstanding", result_queue.size());
    $display("FAILED: results differ");
    $finish;
  end
endmodule
`default_nettype wire

@@ segmented_string_op_unit.f @@
rtl/ssou_pkg.sv
rtl/ssou_ram.sv
rtl/segmented_string_op_unit.sv
tb/sv/tb_segmented_string_op_unit.sv
